// ===== src/tvbs_pkg.sv =====
// shared types and constants for the typed value byte serializer
`default_nettype none

package tvbs_pkg;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 32;
  localparam int STRMAX_W = 31;
  localparam int NBYTES_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] OP_BYTE = 3'd0;
  localparam logic [2:0] OP_U16 = 3'd1;
  localparam logic [2:0] OP_U32 = 3'd2;
  localparam logic [2:0] OP_U64 = 3'd3;
  localparam logic [2:0] OP_VARINT = 3'd4;
  localparam logic [2:0] OP_UTF16 = 3'd5;
  localparam logic [2:0] OP_STR_HDR = 3'd6;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FILE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STRING = 2'd1;

  localparam logic [15:0] SURR_LO = 16'hD800;
  localparam logic [15:0] SURR_HI = 16'hDFFF;
  localparam logic [15:0] UTF8_ONE_LIM = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIM = 16'h0800;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] UTF8_MASK = 8'h3F;
  localparam logic [COUNT_W-1:0] STR_HDR_ROOM = 32'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CAPACITY  = 2'd1,
    ST_SURROGATE = 2'd2,
    ST_STR_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    logic [NBYTES_W-1:0] nbytes;
    status_t             status;
    logic                ignore;
  } enc_result_t;

endpackage

`default_nettype wire

// ===== src/typed_value_byte_serializer_core.sv =====
// Typed value byte serializer: first result in the cycle after a transaction is accepted.
// An item of n bytes gives n results (8 for u64), one per cycle while out_ready is high;
// error items give one zero result, ignored ops none. The next transaction is accepted at the
// edge where the last result of the current one is taken; the one-byte output port sets the rate.
// Synchronous reset clears the byte count and emitter busy state and sets both limits to max.
`default_nettype none

module typed_value_byte_serializer_core
  import tvbs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             op,
  input  wire logic [VALUE_W-1:0]     value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic [1:0]                  status,
  output logic                        last,
  output logic [COUNT_W-1:0]          bytes_written
);

  logic [COUNT_W-1:0]  max_file_bytes;
  logic [STRMAX_W-1:0] max_string_bytes;
  logic [COUNT_W-1:0]  byte_count;
  enc_result_t         enc;
  logic                accept;
  logic                load;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign load = accept && !enc.ignore;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_file_bytes <= '1;
      max_string_bytes <= '1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAX_FILE) begin
        max_file_bytes <= cfg_data;
      end else if (cfg_index == CFG_MAX_STRING) begin
        max_string_bytes <= cfg_data[STRMAX_W-1:0];
      end
    end
  end

  // committed count, ahead of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (load && (enc.status == ST_OK)) begin
      byte_count <= byte_count + {{(COUNT_W-NBYTES_W){1'b0}}, enc.nbytes};
    end
  end

  tvbs_encoder u_encoder (
    .op               (op),
    .value            (value),
    .byte_count       (byte_count),
    .max_file_bytes   (max_file_bytes),
    .max_string_bytes (max_string_bytes),
    .enc              (enc)
  );

  tvbs_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .enc           (enc),
    .base_count    (byte_count),
    .load_ready    (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .status        (status),
    .last          (last),
    .bytes_written (bytes_written)
  );

endmodule

`default_nettype wire

// ===== src/tvbs_encoder.sv =====
// combinational encoder: byte image, length and limit checks of one transaction
`default_nettype none

module tvbs_encoder
  import tvbs_pkg::*;
(
  input  wire logic [2:0]          op,
  input  wire logic [VALUE_W-1:0]  value,
  input  wire logic [COUNT_W-1:0]  byte_count,
  input  wire logic [COUNT_W-1:0]  max_file_bytes,
  input  wire logic [STRMAX_W-1:0] max_string_bytes,
  output enc_result_t              enc
);

  logic [31:0]         var_src;
  logic [34:0]         var_ext;
  logic [NBYTES_W-1:0] var_len;
  logic [VALUE_W-1:0]  var_data;
  logic [15:0]         code;
  logic [VALUE_W-1:0]  data;
  logic [NBYTES_W-1:0] nbytes;
  logic                surrogate;
  logic                str_long;
  logic [COUNT_W-1:0]  addend;
  logic [COUNT_W:0]    room;
  logic                over;

  always_comb begin
    var_src = (op == OP_STR_HDR) ? value[31:0] : value[31:0];
    var_ext = {3'b000, var_src};
    var_len = 4'd1 + {3'b000, var_src[31:7] != '0} + {3'b000, var_src[31:14] != '0}
            + {3'b000, var_src[31:21] != '0} + {3'b000, var_src[31:28] != '0};
    var_data = '0;
    for (int i = 0; i < 5; i++) begin
      var_data[8*i +: 8] = {(NBYTES_W'(i + 1) < var_len), var_ext[7*i +: 7]};
    end
  end

  always_comb begin
    code = value[15:0];
    surrogate = (code >= SURR_LO) && (code <= SURR_HI);
    str_long = (value[VALUE_W-1:STRMAX_W] != '0) || (value[STRMAX_W-1:0] > max_string_bytes);
    data = '0;
    nbytes = '0;
    case (op)
      OP_BYTE: begin
        data[7:0] = value[7:0];
        nbytes = 4'd1;
      end
      OP_U16: begin
        data[15:0] = value[15:0];
        nbytes = 4'd2;
      end
      OP_U32: begin
        data[31:0] = value[31:0];
        nbytes = 4'd4;
      end
      OP_U64: begin
        data = value;
        nbytes = 4'd8;
      end
      OP_VARINT, OP_STR_HDR: begin
        data = var_data;
        nbytes = var_len;
      end
      OP_UTF16: begin
        if (code < UTF8_ONE_LIM) begin
          data[7:0] = code[7:0];
          nbytes = 4'd1;
        end else if (code < UTF8_TWO_LIM) begin
          data[7:0] = UTF8_LEAD2 | {3'b000, code[10:6]};
          data[15:8] = UTF8_CONT | (code[7:0] & UTF8_MASK);
          nbytes = 4'd2;
        end else begin
          data[7:0] = UTF8_LEAD3 | {4'b0000, code[15:12]};
          data[15:8] = UTF8_CONT | (code[13:6] & UTF8_MASK);
          data[23:16] = UTF8_CONT | (code[7:0] & UTF8_MASK);
          nbytes = 4'd3;
        end
      end
      default: begin
        data = '0;
        nbytes = '0;
      end
    endcase
  end

  always_comb begin
    if (op == OP_STR_HDR) begin
      addend = {1'b0, value[STRMAX_W-1:0]} + STR_HDR_ROOM;
    end else begin
      addend = {{(COUNT_W-NBYTES_W){1'b0}}, nbytes};
    end
    room = {1'b0, byte_count} + {1'b0, addend};
    over = room > {1'b0, max_file_bytes};
  end

  always_comb begin
    enc.ignore = (op != OP_BYTE) && (op != OP_U16) && (op != OP_U32) && (op != OP_U64)
              && (op != OP_VARINT) && (op != OP_UTF16) && (op != OP_STR_HDR);
    enc.status = ST_OK;
    if ((op == OP_UTF16) && surrogate) begin
      enc.status = ST_SURROGATE;
    end else if ((op == OP_STR_HDR) && str_long) begin
      enc.status = ST_STR_LONG;
    end else if (over) begin
      enc.status = ST_CAPACITY;
    end
    enc.data = (enc.status == ST_OK) ? data : '0;
    enc.nbytes = (enc.status == ST_OK) ? nbytes : 4'd1;
  end

endmodule

`default_nettype wire

// ===== src/tvbs_emitter.sv =====
// output register that hands out the bytes of one transaction, one per cycle while out_ready is high
`default_nettype none

module tvbs_emitter
  import tvbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire enc_result_t        enc,
  input  wire logic [COUNT_W-1:0] base_count,
  output logic                    load_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    byte_valid,
  output logic [1:0]              status,
  output logic                    last,
  output logic [COUNT_W-1:0]      bytes_written
);

  logic                busy;
  logic [VALUE_W-1:0]  shift;
  logic [NBYTES_W-1:0] rem;
  logic [COUNT_W-1:0]  cnt;
  status_t             st;

  assign out_valid = busy;
  assign out_byte = shift[7:0];
  assign byte_valid = (st == ST_OK);
  assign status = st;
  assign last = (rem == 4'd1);
  assign bytes_written = cnt;
  assign load_ready = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem <= '0;
    end else if (load) begin
      busy <= 1'b1;
      rem <= enc.nbytes;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end
      rem <= rem - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift <= enc.data;
      st <= enc.status;
      cnt <= (enc.status == ST_OK) ? base_count + 32'd1 : base_count;
    end else if (busy && out_ready) begin
      shift <= {8'h00, shift[VALUE_W-1:8]};
      cnt <= cnt + 32'd1;
    end
  end

  a_error_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && (out_byte == 8'h00))
    else $error("error result not a single zero result");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && (bytes_written == $past(bytes_written) + 32'd1))
    else $error("byte count did not advance by one");

  a_rem_nonzero : assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem != '0) && (rem <= 4'd8))
    else $error("remaining byte count out of range");

  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    load |-> load_ready)
    else $error("load while results still pending");

endmodule

`default_nettype wire

// ===== verif/typed_value_byte_serializer_core_tb.sv =====
// testbench for the typed value byte serializer: directed and random traffic, scoreboard checks
`timescale 1ns / 100ps

module typed_value_byte_serializer_core_tb
  import tvbs_pkg::*;
;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_B = 2'd3;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASES = 10;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [7:0]         data;
    logic               byte_valid;
    status_t            status;
    logic               last;
    logic [COUNT_W-1:0] count;
  } byte_beat_t;

  class byte_stream_model;
    logic [COUNT_W-1:0]  max_file;
    logic [STRMAX_W-1:0] max_string;
    logic [COUNT_W-1:0]  byte_count;
    logic [7:0]          encoded[$];
    byte_beat_t          expected[$];
    int                  failures;

    function new();
      max_file = '1;
      max_string = '1;
      byte_count = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_MAX_FILE) begin
        max_file = d;
      end else if (idx == CFG_MAX_STRING) begin
        max_string = d[STRMAX_W-1:0];
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void add_byte(logic [7:0] x);
      encoded.insert(encoded.size(), x);
    endfunction

    function void add_beat(byte_beat_t b);
      expected.insert(expected.size(), b);
    endfunction

    function void add_varint(logic [31:0] w);
      while (w > 32'h7F) begin
        add_byte({1'b1, w[6:0]});
        w = w >> 7;
      end
      add_byte(w[7:0]);
    endfunction

    function void add_error(status_t code);
      byte_beat_t b;
      b.data = '0;
      b.byte_valid = 1'b0;
      b.status = code;
      b.last = 1'b1;
      b.count = byte_count;
      add_beat(b);
    endfunction

    function void accept_item(logic [2:0] code, logic [VALUE_W-1:0] v);
      logic [15:0] cu;
      logic [63:0] need;
      byte_beat_t  b;
      int          nb;
      encoded.delete();
      nb = 0;
      case (code)
        OP_BYTE: nb = 1;
        OP_U16: nb = 2;
        OP_U32: nb = 4;
        OP_U64: nb = 8;
        OP_VARINT: add_varint(v[31:0]);
        OP_UTF16: begin
          cu = v[15:0];
          if (cu >= SURR_LO && cu <= SURR_HI) begin
            add_error(ST_SURROGATE);
            return;
          end
          if (cu < UTF8_ONE_LIM) begin
            add_byte(cu[7:0]);
          end else if (cu < UTF8_TWO_LIM) begin
            add_byte(UTF8_LEAD2 | {3'd0, cu[10:6]});
            add_byte(UTF8_CONT | {2'd0, cu[5:0]});
          end else begin
            add_byte(UTF8_LEAD3 | {4'd0, cu[15:12]});
            add_byte(UTF8_CONT | {2'd0, cu[11:6]});
            add_byte(UTF8_CONT | {2'd0, cu[5:0]});
          end
        end
        OP_STR_HDR: begin
          if (v > {33'd0, max_string}) begin
            add_error(ST_STR_LONG);
            return;
          end
          need = {32'd0, byte_count} + v + {32'd0, STR_HDR_ROOM};
          if (need > {32'd0, max_file}) begin
            add_error(ST_CAPACITY);
            return;
          end
          add_varint(v[31:0]);
        end
        default: return;
      endcase
      for (int i = 0; i < nb; i++) begin
        add_byte(v[8*i +: 8]);
      end
      need = {32'd0, byte_count} + 64'(encoded.size());
      if (need > {32'd0, max_file}) begin
        add_error(ST_CAPACITY);
        return;
      end
      foreach (encoded[i]) begin
        byte_count++;
        b.data = encoded[i];
        b.byte_valid = 1'b1;
        b.status = ST_OK;
        b.last = (i == encoded.size() - 1);
        b.count = byte_count;
        add_beat(b);
      end
    endfunction

    function void match(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_beat(logic [7:0] ob, logic bv, logic [1:0] st, logic lst,
                             logic [COUNT_W-1:0] bw);
      byte_beat_t e;
      if (expected.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0d", ob, st);
        failures++;
        return;
      end
      e = expected.pop_front();
      match("out_byte", 64'(e.data), 64'(ob));
      match("byte_valid", 64'(e.byte_valid), 64'(bv));
      match("status", 64'(e.status), 64'(st));
      match("last", 64'(e.last), 64'(lst));
      match("bytes_written", 64'(e.count), 64'(bw));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [2:0]             op;
  logic [VALUE_W-1:0]     value;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             out_byte;
  logic                   byte_valid;
  logic [1:0]             status;
  logic                   last;
  logic [COUNT_W-1:0]     bytes_written;

  byte_stream_model golden;
  logic             steady;
  int               items_sent;
  int               cycle_count;
  int               hold;

  typed_value_byte_serializer_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .status(status),
    .last(last),
    .bytes_written(bytes_written)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("typed_value_byte_serializer_core_tb: errors");
      $finish;
    end
  end

  // result side: random backpressure
  initial begin
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      golden.check_beat(out_byte, byte_valid, status, last, bytes_written);
    end
  end

  task automatic send_item(logic [2:0] o, logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    do @(posedge clk); while (!in_ready);
    golden.accept_item(o, v);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    golden.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (golden.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure_phase(int p);
    case (p)
      0: begin
        write_reg(CFG_MAX_FILE, golden.byte_count + $urandom_range(0, 64));
        write_reg(CFG_MAX_STRING, $urandom_range(0, 300));
      end
      1: begin
        write_reg(CFG_MAX_FILE, '0);
        write_reg(CFG_MAX_STRING, '0);
      end
      2: begin
        write_reg(CFG_MAX_FILE, '1);
        write_reg(CFG_MAX_STRING, '1);
      end
      3: begin
        write_reg(CFG_UNUSED_A, $urandom);
        write_reg(CFG_UNUSED_B, $urandom);
        write_reg(CFG_MAX_STRING, '0);
      end
      4: begin
        write_reg(CFG_MAX_FILE, golden.byte_count + $urandom_range(0, 8));
        write_reg(CFG_MAX_STRING, $urandom_range(0, 20));
      end
      default: begin
        write_reg(CFG_MAX_FILE, golden.byte_count + $urandom_range(20, 200));
        if ($urandom_range(0, 3) == 0) begin
          write_reg(CFG_MAX_STRING, $urandom);
        end else begin
          write_reg(CFG_MAX_STRING, $urandom_range(0, 400));
        end
      end
    endcase
  endtask

  task automatic send_random();
    logic [2:0]         o;
    logic [VALUE_W-1:0] v;
    if ($urandom_range(0, 99) < 3) begin
      o = OP_UNUSED;
    end else begin
      o = 3'($urandom_range(OP_BYTE, OP_STR_HDR));
    end
    v = {$urandom, $urandom};
    case (o)
      OP_VARINT: v[31:0] = v[31:0] >> $urandom_range(0, 31);
      OP_UTF16: begin
        case ($urandom_range(0, 3))
          0: v[15:0] = 16'($urandom_range(0, UTF8_ONE_LIM - 1));
          1: v[15:0] = 16'($urandom_range(UTF8_ONE_LIM, UTF8_TWO_LIM - 1));
          2: v[15:0] = 16'($urandom_range(SURR_LO, SURR_HI));
          default: ;
        endcase
      end
      OP_STR_HDR: begin
        case ($urandom_range(0, 4))
          0: v = 64'($urandom_range(0, 12));
          1: v = 64'($urandom_range(0, 400));
          2: v = {33'd0, golden.max_string} + 64'($urandom_range(0, 2)) - 64'd1;
          3: v = v >> $urandom_range(0, 63);
          default: ;
        endcase
      end
      default: ;
    endcase
    send_item(o, v);
    if (o != OP_UNUSED) begin
      items_sent++;
    end
    // short strings are followed by their payload bytes
    if (o == OP_STR_HDR && v <= 12) begin
      for (int i = 0; i < v; i++) begin
        send_item(OP_BYTE, {$urandom, $urandom});
        items_sent++;
      end
    end
  endtask

  initial begin
    golden = new();
    steady = 1'b0;
    items_sent = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_BYTE;
    value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_BYTE, 64'h0);
    send_item(OP_BYTE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_U16, 64'h0000_0000_0000_FFFF);
    send_item(OP_U32, 64'hA5A5_A5A5_DEAD_BEEF);
    send_item(OP_U64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_U64, 64'h0);
    send_item(OP_VARINT, 64'h0);
    send_item(OP_VARINT, 64'h7F);
    send_item(OP_VARINT, 64'h80);
    send_item(OP_VARINT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_UTF16, 64'h7F);
    send_item(OP_UTF16, 64'h80);
    send_item(OP_UTF16, 64'h7FF);
    send_item(OP_UTF16, 64'h800);
    send_item(OP_UTF16, 64'hD7FF);
    send_item(OP_UTF16, 64'hD800);
    send_item(OP_UTF16, 64'hDFFF);
    send_item(OP_UTF16, 64'hE000);
    send_item(OP_UTF16, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_STR_HDR, 64'h0);
    send_item(OP_STR_HDR, 64'd200);
    send_item(OP_STR_HDR, 64'h7FFF_FFFF);
    send_item(OP_STR_HDR, 64'h8000_0000);
    send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_BYTE, 64'h5A);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure_phase(p);
      steady = ($urandom_range(0, 3) == 0);
      while (items_sent < (p + 1) * (RANDOM_ITEMS / PHASES)) begin
        send_random();
      end
    end

    settle();
    if (golden.failures == 0) begin
      $display("typed_value_byte_serializer_core_tb: clean");
    end else begin
      $display("typed_value_byte_serializer_core_tb: errors");
    end
    $finish;
  end

endmodule
